/* hw/rtl/gsm_pkg.sv */
// Shared types and constants for the grid search multilateration core.
// Holds fixed-point widths, register indexes and the control/status structs.
// No dependencies.
package gsm_pkg;

  localparam int FRAC_BITS = 4;
  localparam int FIELD_W   = 20;
  localparam int COORD_W   = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] GRID_LIMIT   = 13'd4096;
  localparam logic [CFG_W-1:0] GRID_RST_VAL = 13'd1024;

  // grid point in fixed point, absolute coordinate difference
  localparam int PX_W  = COORD_W + FRAC_BITS;
  localparam int ABS_W = ((PX_W > FIELD_W - 1) ? PX_W : FIELD_W - 1) + 1;
  localparam int SD_W  = ABS_W + 1;
  localparam int SQ_W  = 2 * ABS_W + 1;
  // rounded root, root iteration
  localparam int RT_W   = ABS_W + 1;
  localparam int OP_W   = 2 * RT_W;
  localparam int REM_W  = RT_W + 2;
  localparam int ITER_W = $clog2(RT_W + 1);
  localparam int DD_W   = 2 * RT_W;

  localparam int SUM_W = 48;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef struct packed {
    logic store;
    logic init;
    logic pt_start;
    logic diff;
    logic mul_x;
    logic mul_y;
    logic sqrt_step;
    logic rnd;
    logic mul_d;
    logic acc;
    logic cmp;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic grid_empty;
    logic count_zero;
    logic last_anchor;
    logic last_point;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/grid_search_multilateration_core.sv */
// An anchor without the last flag is stored and the core waits for more. A last
//   anchor is stored too and starts a scan of a W by H grid against the N stored
//   anchors, using the one-digit-per-cycle root unit.
// Throughput: anchor loads one per cycle; the input stalls during a scan.
// Reset (rst_n, synchronous, active low): grid registers go to 1024, the
//   anchor set is emptied and no result is pending.
module grid_search_multilateration_core #(
  parameter int MAX_ANCHORS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // anchor input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [gsm_pkg::FIELD_W-1:0]  in_anchor_x,
  input  logic signed [gsm_pkg::FIELD_W-1:0]  in_anchor_y,
  input  logic [gsm_pkg::FIELD_W-1:0]         in_anchor_range,
  input  logic                                in_last_anchor,
  // result output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [gsm_pkg::COORD_W-1:0]         out_best_x,
  output logic [gsm_pkg::COORD_W-1:0]         out_best_y,
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gsm_pkg::CFG_W-1:0]           cfg_data
);

  gsm_pkg::cmd_t cmd;
  gsm_pkg::sts_t sts;

  // every configuration transfer completes at once
  assign cfg_ready = 1'b1;

  // controller: anchor loads, then point and anchor loops
  gsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last_anchor),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: memory, distance, root, residual sum, best point
  gsm_dp #(
    .MAX_ANCHORS (MAX_ANCHORS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_valid       (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_anchor_x     (in_anchor_x),
    .in_anchor_y     (in_anchor_y),
    .in_anchor_range (in_anchor_range),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_best_x      (out_best_x),
    .out_best_y      (out_best_y)
  );

endmodule

/* hw/rtl/gsm_ctrl.sv */
// Controller state machine of the grid search multilateration core.
// Sequences anchor loads and the per-point, per-anchor scan steps.
// Depends on gsm_pkg.
module gsm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_stall,
  input  gsm_pkg::sts_t sts,
  output gsm_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_INIT = 4'd1;
  localparam logic [3:0] ST_PT   = 4'd2;
  localparam logic [3:0] ST_RD   = 4'd3;
  localparam logic [3:0] ST_DIFF = 4'd4;
  localparam logic [3:0] ST_MULX = 4'd5;
  localparam logic [3:0] ST_MULY = 4'd6;
  localparam logic [3:0] ST_SQRT = 4'd7;
  localparam logic [3:0] ST_RND  = 4'd8;
  localparam logic [3:0] ST_MULD = 4'd9;
  localparam logic [3:0] ST_ACC  = 4'd10;
  localparam logic [3:0] ST_CMP  = 4'd11;
  localparam logic [3:0] ST_FIN  = 4'd12;

  logic [3:0]                  state_r, state_nxt;
  logic [gsm_pkg::ITER_W-1:0]  iter_r, iter_nxt;
  logic                        accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.store = accept;
        if (accept && in_last) state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = sts.grid_empty ? ST_FIN : ST_PT;
      end
      ST_PT: begin
        cmd.pt_start = 1'b1;
        state_nxt    = sts.count_zero ? ST_CMP : ST_RD;
      end
      ST_RD: begin
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_MULX;
      end
      ST_MULX: begin
        cmd.mul_x = 1'b1;
        state_nxt = ST_MULY;
      end
      ST_MULY: begin
        cmd.mul_y = 1'b1;
        iter_nxt  = '0;
        state_nxt = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        iter_nxt      = iter_r + 1'b1;
        if (iter_r == gsm_pkg::ITER_W'(gsm_pkg::RT_W - 1)) state_nxt = ST_RND;
      end
      ST_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = ST_MULD;
      end
      ST_MULD: begin
        cmd.mul_d = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.last_anchor ? ST_CMP : ST_RD;
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = sts.last_point ? ST_FIN : ST_PT;
      end
      ST_FIN: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule

/* hw/rtl/gsm_dp.sv */
// Datapath of the grid search multilateration core: anchor memory, grid
// counters, distance, root, residual sum and best point. Depends on gsm_pkg.
module gsm_dp #(
  parameter int MAX_ANCHORS = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  gsm_pkg::cmd_t                           cmd,
  output gsm_pkg::sts_t                           sts,
  input  logic                                    cfg_valid,
  input  logic [gsm_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [gsm_pkg::CFG_W-1:0]               cfg_data,
  input  logic signed [gsm_pkg::FIELD_W-1:0]      in_anchor_x,
  input  logic signed [gsm_pkg::FIELD_W-1:0]      in_anchor_y,
  input  logic [gsm_pkg::FIELD_W-1:0]             in_anchor_range,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic [gsm_pkg::COORD_W-1:0]             out_best_x,
  output logic [gsm_pkg::COORD_W-1:0]             out_best_y
);

  localparam int AW = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;
  localparam int CW = $clog2(MAX_ANCHORS + 1);
  localparam int FW = gsm_pkg::FIELD_W;
  localparam int MW = 3 * FW;

  logic [gsm_pkg::CFG_W-1:0]   gw_r, gh_r, w_c, h_c;
  logic [CW-1:0]               count_r;
  logic [AW-1:0]               a_r;
  logic [MW-1:0]               mem [MAX_ANCHORS];
  logic [MW-1:0]               rd_q;
  logic [gsm_pkg::COORD_W-1:0] x_r, y_r, bx_r, by_r, ox_r, oy_r;
  logic                        out_valid_r;

  logic [gsm_pkg::PX_W-1:0]         px_u, py_u;
  logic signed [gsm_pkg::SD_W-1:0]  ddx, ddy;
  logic [gsm_pkg::ABS_W-1:0]        adx_r, ady_r;
  logic [2*gsm_pkg::ABS_W-1:0]      sqx, sqy;
  logic [gsm_pkg::SQ_W-1:0]         sq_r;
  logic [gsm_pkg::OP_W-1:0]         op_r;
  logic [gsm_pkg::REM_W-1:0]        rem_r, rem_sh, trial;
  logic [gsm_pkg::RT_W-1:0]         root_r, root_rnd;
  logic signed [gsm_pkg::RT_W:0]    ds;
  logic [gsm_pkg::RT_W-1:0]         d_r;
  logic [gsm_pkg::DD_W-1:0]         dd_r;
  logic [gsm_pkg::SUM_W:0]          sum_ext;
  logic [gsm_pkg::SUM_W-1:0]        sum_r, least_r;

  // configuration, clamp to the grid limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= gsm_pkg::GRID_RST_VAL;
      gh_r <= gsm_pkg::GRID_RST_VAL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        gsm_pkg::REG_WIDTH:  gw_r <= cfg_data;
        gsm_pkg::REG_HEIGHT: gh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_c = (gw_r > gsm_pkg::GRID_LIMIT) ? gsm_pkg::GRID_LIMIT : gw_r;
  assign h_c = (gh_r > gsm_pkg::GRID_LIMIT) ? gsm_pkg::GRID_LIMIT : gh_r;

  assign sts.grid_empty  = (w_c == '0) || (h_c == '0);
  assign sts.count_zero  = (count_r == '0);
  assign sts.last_anchor = (CW'(a_r) == count_r - 1'b1);
  assign sts.last_point  = ({1'b0, x_r} == w_c - 1'b1) && ({1'b0, y_r} == h_c - 1'b1);
  assign sts.out_free    = !out_valid_r || !out_stall;

  // anchor memory
  always_ff @(posedge clk) begin
    if (cmd.store && (count_r < CW'(MAX_ANCHORS)))
      mem[count_r[AW-1:0]] <= {in_anchor_x, in_anchor_y, in_anchor_range};
    rd_q <= mem[a_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.fin) begin
      count_r <= '0;
    end else if (cmd.store && (count_r < CW'(MAX_ANCHORS))) begin
      count_r <= count_r + 1'b1;
    end
  end

  // distance terms
  assign px_u = gsm_pkg::PX_W'(x_r) << gsm_pkg::FRAC_BITS;
  assign py_u = gsm_pkg::PX_W'(y_r) << gsm_pkg::FRAC_BITS;
  assign ddx  = signed'(gsm_pkg::SD_W'(px_u))
              - gsm_pkg::SD_W'(signed'(rd_q[MW-1 -: FW]));
  assign ddy  = signed'(gsm_pkg::SD_W'(py_u))
              - gsm_pkg::SD_W'(signed'(rd_q[2*FW-1 -: FW]));
  assign sqx  = adx_r * adx_r;
  assign sqy  = ady_r * ady_r;

  // one root digit per step
  assign rem_sh   = {rem_r[gsm_pkg::REM_W-3:0], op_r[gsm_pkg::OP_W-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign root_rnd = root_r + gsm_pkg::RT_W'(rem_r > gsm_pkg::REM_W'(root_r));
  assign ds       = signed'({1'b0, root_rnd})
                  - signed'((gsm_pkg::RT_W + 1)'(rd_q[FW-1:0]));
  assign sum_ext = {1'b0, sum_r} + (gsm_pkg::SUM_W + 1)'(dd_r);

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      adx_r <= ddx[gsm_pkg::SD_W-1] ? gsm_pkg::ABS_W'(-ddx) : gsm_pkg::ABS_W'(ddx);
      ady_r <= ddy[gsm_pkg::SD_W-1] ? gsm_pkg::ABS_W'(-ddy) : gsm_pkg::ABS_W'(ddy);
    end
    if (cmd.mul_x) sq_r <= gsm_pkg::SQ_W'(sqx);
    if (cmd.mul_y) begin
      op_r   <= gsm_pkg::OP_W'(sq_r + gsm_pkg::SQ_W'(sqy));
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      op_r <= op_r << 2;
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[gsm_pkg::RT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[gsm_pkg::RT_W-2:0], 1'b0};
      end
    end
    if (cmd.rnd)   d_r  <= ds[gsm_pkg::RT_W] ? gsm_pkg::RT_W'(-ds) : gsm_pkg::RT_W'(ds);
    if (cmd.mul_d) dd_r <= d_r * d_r;
    if (cmd.pt_start) begin
      sum_r <= '0;
      a_r   <= '0;
    end
    if (cmd.acc) begin
      sum_r <= sum_ext[gsm_pkg::SUM_W] ? gsm_pkg::SUM_MAX : sum_ext[gsm_pkg::SUM_W-1:0];
      a_r   <= a_r + 1'b1;
    end
    if (cmd.init) begin
      least_r <= gsm_pkg::SUM_MAX;
      bx_r    <= '0;
      by_r    <= '0;
      x_r     <= '0;
      y_r     <= '0;
    end
    if (cmd.cmp) begin
      if (sum_r < least_r) begin
        least_r <= sum_r;
        bx_r    <= x_r;
        by_r    <= y_r;
      end
      if ({1'b0, x_r} == w_c - 1'b1) begin
        x_r <= '0;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
    if (cmd.fin) begin
      ox_r <= bx_r;
      oy_r <= by_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_best_x = ox_r;
  assign out_best_y = oy_r;

endmodule
